// ===== hdl/rtet_pkg.sv =====
package rtet_pkg;

  // Plane set held in configuration
  localparam int NPL = 4;
  localparam int NAX = 3;

  // Register map: plane_face0..plane_face3 at indexes 0..3
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_FACE0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PLANES  = 3'd4;

  // Field widths
  localparam int ORG_W  = 24;   // Q11.12
  localparam int DIR_W  = 16;   // Q1.14
  localparam int NRM_W  = 16;   // Q1.14
  localparam int OFS_W  = 16;   // Q11.4
  localparam int TOUT_W = 26;   // Q14.12 reported time

  // Internal widths
  localparam int ND_W   = NRM_W + DIR_W;        // one N*dir term
  localparam int NO_W   = NRM_W + ORG_W;        // one N*origin term
  localparam int LD_W   = ND_W + 2;             // N.dir
  localparam int PN_W   = NO_W + 1;             // plane distance, nonnegative part
  localparam int PNS_W  = PN_W + 1;             // plane distance, signed
  localparam int DEN_W  = LD_W;                 // -N.dir
  localparam int TM_W   = 36;                   // exact entry time
  localparam int DIV_STEPS = TM_W;              // one quotient bit a stage
  localparam int REM0_W = PN_W + 14 - TM_W;     // leading dividend bits
  localparam int ACC_W  = DIR_W + TM_W + 2;     // dir*time + origin*2^14
  localparam int PT_W   = ACC_W - 14;           // hit point, Q.12
  localparam int MP_W   = NRM_W + PT_W;         // one N*point term
  localparam int DIST_W = MP_W + 3;             // N.point + d

  // Tolerances and limits
  localparam logic signed [LD_W-1:0]   FACE_EPS   = LD_W'(268435);
  localparam logic signed [DIST_W-1:0] INSIDE_EPS = DIST_W'(67109);
  localparam logic [TOUT_W-1:0]        TIME_MAX   = {TOUT_W{1'b1}};

  typedef struct packed {
    logic [NAX-1:0][ORG_W-1:0] org;
    logic [NAX-1:0][DIR_W-1:0] dir;
  } ray_t;

  // One plane lane inside the divider
  typedef struct packed {
    logic             cand;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [TM_W-1:0]  w;    // dividend bits still to shift in, quotient shifted in
  } lane_t;

endpackage

// ===== hdl/ray_tetrahedron_intersect.sv =====
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-------------------------------------
// in_      | input     | in_valid / in_stall  | origin_x/y/z Q11.12, dir_x/y/z Q1.14
// out_     | output    | out_valid / out_stall| hit, hit_time Q14.12
// cfg_     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data (one plane)
//
// One ray enters per cycle while out_stall does not hold the pipeline; each result follows its request
// through stage 1, the entry-time divider (one quotient bit per stage, 36 stages), stages P, M, S and the output.
// rst_n (synchronous) clears the valid bits and the planes to zero (no hit).
// out_stall holds the whole pipeline, so in_stall follows a stalled pending result.
module ray_tetrahedron_intersect
  import rtet_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [ORG_W-1:0] in_origin_x,
  input  logic signed [ORG_W-1:0] in_origin_y,
  input  logic signed [ORG_W-1:0] in_origin_z,
  input  logic signed [DIR_W-1:0] in_dir_x,
  input  logic signed [DIR_W-1:0] in_dir_y,
  input  logic signed [DIR_W-1:0] in_dir_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_hit,
  output logic [TOUT_W-1:0]       out_hit_time,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [63:0]             cfg_data
);

  logic adv;
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // Plane registers
  logic [63:0] plane_r [NPL];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NPL; p++) plane_r[p] <= '0;
    end else if (cfg_valid && cfg_index < CFG_NUM_PLANES) begin
      plane_r[cfg_index[1:0]] <= cfg_data;
    end
  end

  logic signed [NRM_W-1:0] nrm_c [NPL][NAX];
  logic signed [OFS_W-1:0] ofs_c [NPL];
  always_comb begin
    for (int p = 0; p < NPL; p++) begin
      for (int c = 0; c < NAX; c++) nrm_c[p][c] = $signed(plane_r[p][16*c +: 16]);
      ofs_c[p] = $signed(plane_r[p][63:48]);
    end
  end

  logic signed [ORG_W-1:0] in_org_c [NAX];
  logic signed [DIR_W-1:0] in_dir_c [NAX];
  assign in_org_c[0] = in_origin_x;
  assign in_org_c[1] = in_origin_y;
  assign in_org_c[2] = in_origin_z;
  assign in_dir_c[0] = in_dir_x;
  assign in_dir_c[1] = in_dir_y;
  assign in_dir_c[2] = in_dir_z;

  // Stage 1: N.dir and N.origin partial products
  logic                   s1_vld_r;
  ray_t                   s1_ray_r;
  logic signed [ND_W-1:0] s1_nd_r [NPL][NAX];
  logic signed [NO_W-1:0] s1_no_r [NPL][NAX];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
    end
    if (adv) begin
      for (int c = 0; c < NAX; c++) begin
        s1_ray_r.org[c] <= in_org_c[c];
        s1_ray_r.dir[c] <= in_dir_c[c];
        for (int p = 0; p < NPL; p++) begin
          s1_nd_r[p][c] <= nrm_c[p][c] * in_dir_c[c];
          s1_no_r[p][c] <= nrm_c[p][c] * in_org_c[c];
        end
      end
    end
  end

  // Stage 2 (divider stage 0): facing test, load dividend and divisor
  logic  dv_vld_r  [DIV_STEPS+1];
  ray_t  dv_ray_r  [DIV_STEPS+1];
  lane_t dv_lane_r [DIV_STEPS+1][NPL];
  lane_t s2_lane_nxt [NPL];

  always_comb begin
    logic signed [LD_W-1:0]  ld;
    logic signed [PNS_W-1:0] pn;
    for (int p = 0; p < NPL; p++) begin
      ld = LD_W'(s1_nd_r[p][0]) + LD_W'(s1_nd_r[p][1]) + LD_W'(s1_nd_r[p][2]);
      pn = (PNS_W'(ofs_c[p]) <<< 22) + PNS_W'(s1_no_r[p][0])
         + PNS_W'(s1_no_r[p][1]) + PNS_W'(s1_no_r[p][2]);
      s2_lane_nxt[p].cand = (ld < -FACE_EPS) && !pn[PNS_W-1];
      s2_lane_nxt[p].den  = DEN_W'(-ld);
      s2_lane_nxt[p].rem  = DEN_W'(pn[PN_W-1 -: REM0_W]);
      s2_lane_nxt[p].w    = {pn[PN_W-REM0_W-1:0], 14'b0};
    end
  end

  // Divider: restoring, one quotient bit per stage and lane
  function automatic lane_t div_step(lane_t l);
    logic [DEN_W:0] t;
    logic           ge;
    lane_t          s;
    t      = {l.rem, l.w[TM_W-1]};
    ge     = t >= {1'b0, l.den};
    s.cand = l.cand;
    s.den  = l.den;
    s.rem  = ge ? DEN_W'(t - {1'b0, l.den}) : DEN_W'(t);
    s.w    = {l.w[TM_W-2:0], ge};
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_STEPS; k++) dv_vld_r[k] <= 1'b0;
    end else if (adv) begin
      dv_vld_r[0] <= s1_vld_r;
      for (int k = 0; k < DIV_STEPS; k++) dv_vld_r[k+1] <= dv_vld_r[k];
    end
    if (adv) begin
      dv_ray_r[0] <= s1_ray_r;
      for (int p = 0; p < NPL; p++) dv_lane_r[0][p] <= s2_lane_nxt[p];
      for (int k = 0; k < DIV_STEPS; k++) begin
        dv_ray_r[k+1] <= dv_ray_r[k];
        for (int p = 0; p < NPL; p++) dv_lane_r[k+1][p] <= div_step(dv_lane_r[k][p]);
      end
    end
  end

  // Stage P: hit point per candidate, floor of (dir*t + org*2^14) / 2^14
  logic                   sp_vld_r;
  logic                   sp_cand_r [NPL];
  logic [TM_W-1:0]        sp_tm_r   [NPL];
  logic signed [PT_W-1:0] sp_pt_r   [NPL][NAX];
  always_ff @(posedge clk) begin
    logic signed [ACC_W-1:0] acc;
    if (!rst_n) begin
      sp_vld_r <= 1'b0;
    end else if (adv) begin
      sp_vld_r <= dv_vld_r[DIV_STEPS];
    end
    if (adv) begin
      for (int p = 0; p < NPL; p++) begin
        sp_cand_r[p] <= dv_lane_r[DIV_STEPS][p].cand;
        sp_tm_r[p]   <= dv_lane_r[DIV_STEPS][p].w;
        for (int c = 0; c < NAX; c++) begin
          acc = $signed(dv_ray_r[DIV_STEPS].dir[c]) * $signed({1'b0, dv_lane_r[DIV_STEPS][p].w})
              + (ACC_W'($signed(dv_ray_r[DIV_STEPS].org[c])) <<< 14);
          sp_pt_r[p][c] <= acc[ACC_W-1:14];
        end
      end
    end
  end

  // Stage M: N.point partial products, every candidate against every plane
  logic                   sm_vld_r;
  logic                   sm_cand_r [NPL];
  logic [TM_W-1:0]        sm_tm_r   [NPL];
  logic signed [MP_W-1:0] sm_mp_r   [NPL][NPL][NAX];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm_vld_r <= 1'b0;
    end else if (adv) begin
      sm_vld_r <= sp_vld_r;
    end
    if (adv) begin
      for (int t = 0; t < NPL; t++) begin
        sm_cand_r[t] <= sp_cand_r[t];
        sm_tm_r[t]   <= sp_tm_r[t];
        for (int q = 0; q < NPL; q++)
          for (int c = 0; c < NAX; c++)
            sm_mp_r[t][q][c] <= nrm_c[q][c] * sp_pt_r[t][c];
      end
    end
  end

  // Stage S: distance to the other planes, inside test
  logic            ss_vld_r;
  logic            ss_ok_r [NPL];
  logic [TM_W-1:0] ss_tm_r [NPL];
  logic            ok_nxt  [NPL];
  always_comb begin
    logic signed [DIST_W-1:0] pl_dist;
    for (int t = 0; t < NPL; t++) begin
      ok_nxt[t] = sm_cand_r[t];
      for (int q = 0; q < NPL; q++) begin
        pl_dist = DIST_W'(sm_mp_r[t][q][0]) + DIST_W'(sm_mp_r[t][q][1])
                + DIST_W'(sm_mp_r[t][q][2]) + (DIST_W'(ofs_c[q]) <<< 22);
        if (q != t && pl_dist > INSIDE_EPS) ok_nxt[t] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ss_vld_r <= 1'b0;
    end else if (adv) begin
      ss_vld_r <= sm_vld_r;
    end
    if (adv) begin
      for (int t = 0; t < NPL; t++) begin
        ss_ok_r[t] <= ok_nxt[t];
        ss_tm_r[t] <= sm_tm_r[t];
      end
    end
  end

  // Earliest passing candidate; strict compare keeps the lower plane on ties
  logic            found_c;
  logic [TM_W-1:0] best_c;
  always_comb begin
    found_c = 1'b0;
    best_c  = '0;
    for (int t = 0; t < NPL; t++) begin
      if (ss_ok_r[t] && (!found_c || ss_tm_r[t] < best_c)) begin
        found_c = 1'b1;
        best_c  = ss_tm_r[t];
      end
    end
  end

  // Output register
  logic              out_vld_r;
  logic              out_hit_r;
  logic [TOUT_W-1:0] out_time_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= ss_vld_r;
    end
    if (adv) begin
      out_hit_r  <= found_c;
      out_time_r <= (best_c > TM_W'(TIME_MAX)) ? TIME_MAX : best_c[TOUT_W-1:0];
    end
  end

  assign out_valid    = out_vld_r;
  assign out_hit      = out_hit_r;
  assign out_hit_time = out_time_r;

`ifndef SYNTHESIS
  // Input is held back only behind a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid) else $error("in_stall without a pending result");
  // No-hit results report time zero
  a_miss_time: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> out_hit_time == '0) else $error("miss with nonzero time");
  // A stall freezes the pipeline valid chain
  a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> ($stable(s1_vld_r) && $stable(ss_vld_r)))
    else $error("pipeline moved during stall");
`endif

endmodule
